[rtl/core/tqvg_pkg.sv]
// Shared types and constants of the tile quad vertex generator.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package tqvg_pkg;

	// Configuration port
	localparam int REG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [REG_IDX_W-1:0] REG_FIRST_TILE_ID = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LAST_TILE_ID = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SHEET_COLUMNS = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SHEET_TILE_WIDTH = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SHEET_TILE_HEIGHT = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_GRID_CELL_WIDTH = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_GRID_CELL_HEIGHT = 3'd6;

	// Corner codes, in emission order
	localparam logic [1:0] CORNER_TL = 2'd0;
	localparam logic [1:0] CORNER_TR = 2'd1;
	localparam logic [1:0] CORNER_BR = 2'd2;
	localparam logic [1:0] CORNER_BL = 2'd3;

	// Flip flag bit positions
	localparam int FLIP_H_BIT = 2;
	localparam int FLIP_V_BIT = 1;
	localparam int FLIP_D_BIT = 0;

	// Depth of the queue between the front and the back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [15:0] first_tile_id;
		logic [15:0] last_tile_id;
		logic [12:0] sheet_columns;
		logic [10:0] sheet_tile_width;
		logic [10:0] sheet_tile_height;
		logic [10:0] grid_cell_width;
		logic [10:0] grid_cell_height;
	} cfg_t;

	// A tile that passed classification: index inside the set plus placement
	typedef struct packed {
		logic [15:0] tile_index;
		logic [2:0]  flip_flags;
		logic [4:0]  cell_column;
		logic [4:0]  cell_row;
	} tile_t;

	// Tile index split into sheet row (quotient) and sheet column (remainder)
	typedef struct packed {
		logic [15:0] sheet_row;
		logic [12:0] sheet_col;
		logic [2:0]  flip_flags;
		logic [4:0]  cell_column;
		logic [4:0]  cell_row;
	} split_t;

	// Handshake between two internal stages
	typedef struct packed {
		logic valid;
		logic ready;
	} link_t;

endpackage

`default_nettype wire

[rtl/core/tqvg_front.sv]
// Front end: accepts tile words, drops those outside the set or the chunk.
// Depends on tqvg_pkg.
`default_nettype none

module tqvg_front #(
	parameter int CHUNK_SIDE = 32
) (
	input  wire                  queue_full,
	input  wire                  start,
	input  wire  [15:0]          tile_id,
	input  wire  [2:0]           flip_flags,
	input  wire  [4:0]           cell_column,
	input  wire  [4:0]           cell_row,
	input  tqvg_pkg::cfg_t       cfg,
	output logic                 busy,
	output logic                 push,
	output tqvg_pkg::tile_t      push_tile
);

	localparam logic [8:0] CHUNK_LIMIT = 9'(CHUNK_SIDE);

	logic in_set;
	logic in_chunk;

	assign in_set = (tile_id >= cfg.first_tile_id) && (tile_id <= cfg.last_tile_id);
	assign in_chunk = ({4'd0, cell_column} < CHUNK_LIMIT) && ({4'd0, cell_row} < CHUNK_LIMIT);

	assign busy = queue_full;
	assign push = start && !queue_full && in_set && in_chunk;

	always_comb begin
		push_tile.tile_index = tile_id - cfg.first_tile_id;
		push_tile.flip_flags = flip_flags;
		push_tile.cell_column = cell_column;
		push_tile.cell_row = cell_row;
	end

endmodule

`default_nettype wire

[rtl/core/tqvg_queue.sv]
// Short queue of classified tiles between the front and the back.
// Depends on tqvg_pkg.
`default_nettype none

module tqvg_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  tqvg_pkg::tile_t  push_tile,
	input  wire              pop,
	output logic             full,
	output logic             not_empty,
	output tqvg_pkg::tile_t  head
);

	tqvg_pkg::tile_t                     entry_q [tqvg_pkg::QUEUE_DEPTH];
	logic [tqvg_pkg::QUEUE_PTR_W-1:0]    wr_ptr_q;
	logic [tqvg_pkg::QUEUE_PTR_W-1:0]    rd_ptr_q;
	logic [tqvg_pkg::QUEUE_PTR_W:0]      count_q;

	localparam logic [tqvg_pkg::QUEUE_PTR_W:0] DEPTH_COUNT =
		(tqvg_pkg::QUEUE_PTR_W+1)'(tqvg_pkg::QUEUE_DEPTH);

	assign full = (count_q == DEPTH_COUNT);
	assign not_empty = (count_q != '0);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_tile;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/tqvg_divider.sv]
// Back end, first part: splits the tile index by the sheet column count,
// four quotient bits a cycle unless its output is held, sixteen bits in all.
// Depends on tqvg_pkg.
`default_nettype none

module tqvg_divider (
	input  wire               clk,
	input  wire               arst_n,
	input  tqvg_pkg::cfg_t    cfg,
	input  wire               queue_not_empty,
	input  tqvg_pkg::tile_t   queue_head,
	output logic              pop,
	output logic              out_valid,
	input  wire               out_ready,
	output tqvg_pkg::split_t  out_split
);

	logic                     busy_q;
	logic [1:0]               step_q;
	logic [15:0]              dvd_q;
	logic [12:0]              rem_q;
	tqvg_pkg::tile_t          tile_q;
	logic                     valid_s1;
	tqvg_pkg::split_t         split_s1;

	logic [12:0]              divisor;
	logic [15:0]              dvd_next;
	logic [12:0]              rem_next;
	logic                     out_free;
	logic                     finish;
	logic                     load;

	assign divisor = (cfg.sheet_columns == '0) ? 13'd1 : cfg.sheet_columns;

	// Four restoring steps; quotient bits shift in at the low end of the dividend.
	always_comb begin
		logic [13:0] trial;
		logic [15:0] d;
		logic [12:0] r;
		d = dvd_q;
		r = rem_q;
		for (int i = 0; i < 4; i++) begin
			trial = {r, d[15]};
			d = {d[14:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				r = 13'(trial - {1'b0, divisor});
				d[0] = 1'b1;
			end else begin
				r = trial[12:0];
			end
		end
		dvd_next = d;
		rem_next = r;
	end

	assign out_free = !valid_s1 || out_ready;
	assign finish = busy_q && (step_q == 2'd3) && out_free;
	assign load = queue_not_empty && (!busy_q || finish);
	assign pop = load;

	assign out_valid = valid_s1;
	assign out_split = split_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
			valid_s1 <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (finish) begin
				busy_q <= 1'b0;
			end else if (busy_q && (step_q != 2'd3)) begin
				step_q <= step_q + 2'd1;
			end
			if (finish) begin
				valid_s1 <= 1'b1;
			end else if (out_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q <= queue_head.tile_index;
			rem_q <= '0;
			tile_q <= queue_head;
		end else if (busy_q && (step_q != 2'd3)) begin
			dvd_q <= dvd_next;
			rem_q <= rem_next;
		end
		if (finish) begin
			split_s1.sheet_row <= dvd_next;
			split_s1.sheet_col <= rem_next;
			split_s1.flip_flags <= tile_q.flip_flags;
			split_s1.cell_column <= tile_q.cell_column;
			split_s1.cell_row <= tile_q.cell_row;
		end
	end

endmodule

`default_nettype wire

[rtl/core/tqvg_emitter.sv]
// Back end, second part: multiplies out the quad, saturates texture
// coordinates and sends the four corners, one a cycle. Depends on tqvg_pkg.
`default_nettype none

module tqvg_emitter (
	input  wire                 clk,
	input  wire                 arst_n,
	input  tqvg_pkg::cfg_t      cfg,
	input  wire                 in_valid,
	input  tqvg_pkg::split_t    in_split,
	output logic                in_ready,
	output logic                strobe,
	output logic [1:0]          corner_index,
	output logic signed [16:0]  screen_x,
	output logic signed [16:0]  screen_y,
	output logic [15:0]         texel_u,
	output logic [15:0]         texel_v,
	output logic                last_corner
);

	function automatic logic [15:0] sat16(input logic [27:0] x);
		return (x[27:16] != '0) ? 16'hFFFF : x[15:0];
	endfunction

	// Product stage
	logic         valid_s2;
	logic [23:0]  base_u_s2;
	logic [26:0]  base_v_s2;
	logic [15:0]  sx0_s2;
	logic [15:0]  ry_s2;
	logic [2:0]   flags_s2;

	// Quad being sent
	logic         quad_valid_q;
	logic [1:0]   corner_q;
	logic [15:0]  u_left_q;
	logic [15:0]  u_right_q;
	logic [15:0]  v_top_q;
	logic [15:0]  v_bottom_q;
	logic [16:0]  sx0_q;
	logic [16:0]  sy0_q;
	logic         swap_lr_q;
	logic         swap_tb_q;
	logic         diag_q;

	// Output registers
	logic         strobe_q;
	logic [1:0]   corner_out_q;
	logic [16:0]  sx_out_q;
	logic [16:0]  sy_out_q;
	logic [15:0]  u_out_q;
	logic [15:0]  v_out_q;

	logic         quad_free;
	logic         s2_take;
	logic         s2_load;
	logic         flip_h;
	logic         flip_v;
	logic         flip_d;
	logic [1:0]   tex_corner;
	logic         dx_scr;
	logic         dy_scr;
	logic         dx_tex;
	logic         dy_tex;

	assign quad_free = !quad_valid_q || (corner_q == tqvg_pkg::CORNER_BL);
	assign s2_take = valid_s2 && quad_free;
	assign s2_load = in_valid && (!valid_s2 || s2_take);
	assign in_ready = !valid_s2 || s2_take;

	assign flip_h = flags_s2[tqvg_pkg::FLIP_H_BIT];
	assign flip_v = flags_s2[tqvg_pkg::FLIP_V_BIT];
	assign flip_d = flags_s2[tqvg_pkg::FLIP_D_BIT];

	// With the diagonal flag, corners TR and BL trade texture coordinates.
	assign tex_corner = (diag_q && corner_q[0]) ? {~corner_q[1], corner_q[0]} : corner_q;
	assign dx_scr = corner_q[1] ^ corner_q[0];
	assign dy_scr = corner_q[1];
	assign dx_tex = (tex_corner[1] ^ tex_corner[0]) ^ swap_lr_q;
	assign dy_tex = tex_corner[1] ^ swap_tb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			quad_valid_q <= 1'b0;
			corner_q <= tqvg_pkg::CORNER_TL;
			strobe_q <= 1'b0;
		end else begin
			if (s2_load) begin
				valid_s2 <= 1'b1;
			end else if (s2_take) begin
				valid_s2 <= 1'b0;
			end
			if (s2_take) begin
				quad_valid_q <= 1'b1;
				corner_q <= tqvg_pkg::CORNER_TL;
			end else if (quad_valid_q) begin
				if (corner_q == tqvg_pkg::CORNER_BL) begin
					quad_valid_q <= 1'b0;
				end
				corner_q <= corner_q + 2'd1;
			end
			strobe_q <= quad_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			base_u_s2 <= 24'(in_split.sheet_col) * 24'(cfg.sheet_tile_width);
			base_v_s2 <= 27'(in_split.sheet_row) * 27'(cfg.sheet_tile_height);
			sx0_s2 <= 16'(in_split.cell_column) * 16'(cfg.grid_cell_width);
			ry_s2 <= 16'(in_split.cell_row) * 16'(cfg.grid_cell_height);
			flags_s2 <= in_split.flip_flags;
		end
		if (s2_take) begin
			u_left_q <= sat16({4'd0, base_u_s2});
			u_right_q <= sat16(28'(base_u_s2) + 28'(cfg.sheet_tile_width));
			v_top_q <= sat16({1'b0, base_v_s2});
			v_bottom_q <= sat16(28'(base_v_s2) + 28'(cfg.sheet_tile_height));
			sx0_q <= {1'b0, sx0_s2};
			sy0_q <= 17'(ry_s2) + 17'(cfg.grid_cell_height) - 17'(cfg.sheet_tile_height);
			swap_lr_q <= flip_d ? flip_v : flip_h;
			swap_tb_q <= flip_d ? flip_h : flip_v;
			diag_q <= flip_d;
		end
		if (quad_valid_q) begin
			corner_out_q <= corner_q;
			sx_out_q <= sx0_q + (dx_scr ? 17'(cfg.sheet_tile_width) : 17'd0);
			sy_out_q <= sy0_q + (dy_scr ? 17'(cfg.sheet_tile_height) : 17'd0);
			u_out_q <= dx_tex ? u_right_q : u_left_q;
			v_out_q <= dy_tex ? v_bottom_q : v_top_q;
		end
	end

	assign strobe = strobe_q;
	assign corner_index = corner_out_q;
	assign screen_x = sx_out_q;
	assign screen_y = sy_out_q;
	assign texel_u = u_out_q;
	assign texel_v = v_out_q;
	assign last_corner = (corner_out_q == tqvg_pkg::CORNER_BL);

endmodule

`default_nettype wire

[rtl/core/tile_quad_vertex_generator_top.sv]
// Top level of the tile quad vertex generator: configuration registers and
// the front, queue, divider and emitter. Depends on tqvg_pkg and those modules.
`default_nettype none

// Usage
// A map tile word (tile_id, flip_flags, cell_column, cell_row) is taken at a
// rising edge where start is high and busy is low. The front checks the id
// against the configured set and the cell against the chunk; a word that
// fails either check is taken and produces nothing. A word that passes
// produces four corner words, top-left, top-right, bottom-right, bottom-left,
// each on the result ports for one cycle with strobe high; last_corner marks
// the fourth. The divider that splits the tile index by the sheet column
// count (four quotient bits a cycle unless the emitter holds its result) and
// the emitter (one corner per cycle) each start their next tile as they
// finish the current one. A four-entry queue sits between the front and the
// back, so busy rises only when it fills; the receiver cannot stall the
// results, so the back never waits on the output. Configuration is written
// through wr_en, wr_index and wr_data while the block is idle; unknown
// indexes are ignored. The block itself does not enforce that; the user must.
// Reset clears all control state and restores the register reset values; no
// words are in flight after reset.
module tile_quad_vertex_generator_top #(
	parameter int CHUNK_SIDE = 32
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	output logic                                 busy,
	input  wire  [15:0]                          tile_id,
	input  wire  [2:0]                           flip_flags,
	input  wire  [4:0]                           cell_column,
	input  wire  [4:0]                           cell_row,
	input  wire                                  wr_en,
	input  wire  [tqvg_pkg::REG_IDX_W-1:0]       wr_index,
	input  wire  [tqvg_pkg::CFG_DATA_W-1:0]      wr_data,
	output logic                                 strobe,
	output logic [1:0]                           corner_index,
	output logic signed [16:0]                   screen_x,
	output logic signed [16:0]                   screen_y,
	output logic [15:0]                          texel_u,
	output logic [15:0]                          texel_v,
	output logic                                 last_corner
);

	tqvg_pkg::cfg_t    cfg_q;
	logic              queue_full;
	logic              queue_not_empty;
	logic              push;
	logic              pop;
	tqvg_pkg::tile_t   push_tile;
	tqvg_pkg::tile_t   queue_head;
	logic              split_valid;
	tqvg_pkg::split_t  split;
	logic              emit_ready;

	// Configuration registers; each register keeps the low bits of the word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_tile_id <= 16'd1;
			cfg_q.last_tile_id <= 16'd1;
			cfg_q.sheet_columns <= 13'd1;
			cfg_q.sheet_tile_width <= 11'd16;
			cfg_q.sheet_tile_height <= 11'd16;
			cfg_q.grid_cell_width <= 11'd16;
			cfg_q.grid_cell_height <= 11'd16;
		end else if (wr_en) begin
			case (wr_index)
				tqvg_pkg::REG_FIRST_TILE_ID: cfg_q.first_tile_id <= wr_data;
				tqvg_pkg::REG_LAST_TILE_ID: cfg_q.last_tile_id <= wr_data;
				tqvg_pkg::REG_SHEET_COLUMNS: cfg_q.sheet_columns <= wr_data[12:0];
				tqvg_pkg::REG_SHEET_TILE_WIDTH: cfg_q.sheet_tile_width <= wr_data[10:0];
				tqvg_pkg::REG_SHEET_TILE_HEIGHT: cfg_q.sheet_tile_height <= wr_data[10:0];
				tqvg_pkg::REG_GRID_CELL_WIDTH: cfg_q.grid_cell_width <= wr_data[10:0];
				tqvg_pkg::REG_GRID_CELL_HEIGHT: cfg_q.grid_cell_height <= wr_data[10:0];
				default: begin
				end
			endcase
		end
	end

	// The front classifies each word in the cycle it is taken.
	tqvg_front #(
		.CHUNK_SIDE(CHUNK_SIDE)
	) u_front (
		.queue_full  (queue_full),
		.start       (start),
		.tile_id     (tile_id),
		.flip_flags  (flip_flags),
		.cell_column (cell_column),
		.cell_row    (cell_row),
		.cfg         (cfg_q),
		.busy        (busy),
		.push        (push),
		.push_tile   (push_tile)
	);

	tqvg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_tile (push_tile),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (queue_not_empty),
		.head      (queue_head)
	);

	// The divider hands its result on at the edge that ends its last step
	// and starts the next waiting tile at that same edge.
	tqvg_divider u_divider (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.queue_not_empty (queue_not_empty),
		.queue_head      (queue_head),
		.pop             (pop),
		.out_valid       (split_valid),
		.out_ready       (emit_ready),
		.out_split       (split)
	);

	tqvg_emitter u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (split_valid),
		.in_split     (split),
		.in_ready     (emit_ready),
		.strobe       (strobe),
		.corner_index (corner_index),
		.screen_x     (screen_x),
		.screen_y     (screen_y),
		.texel_u      (texel_u),
		.texel_v      (texel_v),
		.last_corner  (last_corner)
	);

endmodule

`default_nettype wire
